[rtl/core/dbn_pkg.sv]
// ----------------------------------------------------------------------------
// dbn_pkg
// Shared types and constants for the decimal add / subtract / multiply block.
// ----------------------------------------------------------------------------
package dbn_pkg;

    localparam int DIGIT_W    = 4;
    localparam int CHUNK_W    = 64;
    localparam int MAX_CHUNK  = CHUNK_W / DIGIT_W;
    localparam int OP_W       = 2;

    // reciprocal of ten for values below one hundred: q = (t * 205) >> 11
    localparam int RECIP_TEN   = 205;
    localparam int RECIP_SHIFT = 11;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [OP_W-1:0]    op_t;

    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;

    // commands broadcast to every digit cell
    typedef logic [2:0] cell_cmd_t;

    localparam cell_cmd_t CMD_HOLD  = 3'd0;
    localparam cell_cmd_t CMD_LOAD  = 3'd1;
    localparam cell_cmd_t CMD_CLEAR = 3'd2;
    localparam cell_cmd_t CMD_MUL   = 3'd3;
    localparam cell_cmd_t CMD_ADD   = 3'd4;
    localparam cell_cmd_t CMD_SUB   = 3'd5;
    localparam cell_cmd_t CMD_FLUSH = 3'd6;
    localparam cell_cmd_t CMD_EMIT  = 3'd7;

    typedef struct packed {
        cell_cmd_t cmd;
        digit_t    b_sel;
    } cell_ctrl_t;

endpackage

[rtl/core/dbn_in_if.sv]
// ----------------------------------------------------------------------------
// dbn_in_if
// Operand channel: one beat carries one chunk of both operands.
// ----------------------------------------------------------------------------
interface dbn_in_if
    import dbn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      op;
    logic [CHUNK_W-1:0]   a_digits;
    logic [CHUNK_W-1:0]   b_digits;
    logic                 last;

    modport source (output valid, op, a_digits, b_digits, last, input ready);
    modport sink   (input valid, op, a_digits, b_digits, last, output ready);
endinterface

[rtl/core/dbn_out_if.sv]
// ----------------------------------------------------------------------------
// dbn_out_if
// Result channel: one beat carries one chunk of the result.
// ----------------------------------------------------------------------------
interface dbn_out_if
    import dbn_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHUNK_W-1:0]   result_digits;
    logic                 result_last;
    logic                 bad_digit;

    modport source (output valid, result_digits, result_last, bad_digit, input ready);
    modport sink   (input valid, result_digits, result_last, bad_digit, output ready);
endinterface

[rtl/core/decimal_bignum_alu.sv]
// ----------------------------------------------------------------------------
// decimal_bignum_alu
// Fixed-length decimal add / subtract / multiply over a row of digit cells.
// ----------------------------------------------------------------------------
// Loading accepts one chunk per beat; ready is low while an operation runs.
// After the last beat: pad steps load zero chunks up to NCHUNKS, a clear step,
// then multiply row steps or an add/subtract step, then carry flush steps over
// the NCELL cells (NCELL = NCHUNKS * CHUNK_DIGITS), then NCHUNKS result beats;
// an undefined op goes from the clear step straight to the beats.
// Reset clears the state machine, counters and the bad digit flag.
// ----------------------------------------------------------------------------
module decimal_bignum_alu
    import dbn_pkg::*;
#(
    parameter int DIGITS       = 256,
    parameter int CHUNK_DIGITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    dbn_in_if.sink     operands,
    dbn_out_if.source  results
);

    localparam int NCHUNKS = (DIGITS + CHUNK_DIGITS - 1) / CHUNK_DIGITS;
    localparam int NCELL   = NCHUNKS * CHUNK_DIGITS;
    localparam int CW      = $clog2(NCHUNKS + 1);
    localparam int SW      = $clog2(NCELL + 1);
    localparam int IW      = $clog2(NCELL + 1) + 1;

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_PAD    = 3'd1;
    localparam logic [2:0] S_CLEAR  = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_ADDSUB = 3'd4;
    localparam logic [2:0] S_FLUSH  = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [2:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [SW-1:0]  step_reg, step_next;
    op_t            op_reg, op_next;
    logic           bad_reg, bad_next;

    digit_t         a_q [NCELL];
    digit_t         b_q [NCELL];
    digit_t         r_q [NCELL];
    digit_t         c_q [NCELL];
    digit_t         a_chunk [CHUNK_DIGITS];
    digit_t         b_chunk [CHUNK_DIGITS];
    logic           chunk_bad;
    logic           in_beat;
    logic           out_beat;
    logic           room;
    logic [IW-1:0]  base;
    digit_t         carry0;
    cell_ctrl_t     ctrl;
    logic [CHUNK_W-1:0] out_word;

    assign in_beat  = operands.valid && operands.ready;
    assign out_beat = results.valid && results.ready;
    assign room     = count_reg < CW'(NCHUNKS);
    assign base     = IW'(count_reg) * IW'(CHUNK_DIGITS);

    // clean the incoming chunk: fold bad nibbles, zero unused positions
    always_comb
    begin
        digit_t na;
        digit_t nb;
        chunk_bad = 1'b0;
        for (int k = 0; k < CHUNK_DIGITS; k++)
        begin
            na = operands.a_digits[DIGIT_W*k +: DIGIT_W];
            nb = operands.b_digits[DIGIT_W*k +: DIGIT_W];
            a_chunk[k] = '0;
            b_chunk[k] = '0;
            if (state_reg == S_LOAD && base + IW'(k) < IW'(DIGITS))
            begin
                if (na > 4'd9)
                begin
                    chunk_bad = 1'b1;
                    na = na - 4'd10;
                end
                if (nb > 4'd9)
                begin
                    chunk_bad = 1'b1;
                    nb = nb - 4'd10;
                end
                a_chunk[k] = na;
                b_chunk[k] = nb;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        op_next    = op_reg;
        bad_next   = bad_reg;
        ctrl.cmd   = CMD_HOLD;
        ctrl.b_sel = b_q[0];
        carry0     = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_beat)
                begin
                    if (room)
                    begin
                        ctrl.cmd   = CMD_LOAD;
                        count_next = count_reg + CW'(1);
                        bad_next   = bad_reg | chunk_bad;
                    end
                    if (operands.last)
                    begin
                        op_next = operands.op;
                        if (count_next < CW'(NCHUNKS))
                        begin
                            state_next = S_PAD;
                        end
                        else
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_PAD:
            begin
                ctrl.cmd   = CMD_LOAD;
                count_next = count_reg + CW'(1);
                if (count_next == CW'(NCHUNKS))
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                ctrl.cmd   = CMD_CLEAR;
                count_next = '0;
                step_next  = '0;
                if (op_reg == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else if (op_reg == OP_ADD || op_reg == OP_SUB)
                begin
                    state_next = S_ADDSUB;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MUL:
            begin
                ctrl.cmd  = CMD_MUL;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(DIGITS - 1))
                begin
                    step_next  = '0;
                    state_next = S_FLUSH;
                end
            end
            S_ADDSUB:
            begin
                if (op_reg == OP_SUB)
                begin
                    ctrl.cmd = CMD_SUB;
                    carry0   = 4'd1;
                end
                else
                begin
                    ctrl.cmd = CMD_ADD;
                end
                step_next  = '0;
                state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                ctrl.cmd  = CMD_FLUSH;
                step_next = step_reg + SW'(1);
                if (step_reg == SW'(NCELL - 1))
                begin
                    step_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_beat)
                begin
                    ctrl.cmd   = CMD_EMIT;
                    count_next = count_reg + CW'(1);
                    if (count_reg == CW'(NCHUNKS - 1))
                    begin
                        count_next = '0;
                        bad_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            step_reg  <= '0;
            op_reg    <= OP_ADD;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            op_reg    <= op_next;
            bad_reg   <= bad_next;
        end
    end

    // row of digit cells
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        digit_t a_ld;
        digit_t b_ld;
        digit_t a_lo;
        digit_t b_hi;
        digit_t r_hi;
        digit_t c_in;

        if (i + CHUNK_DIGITS < NCELL)
        begin : g_mid
            assign a_ld = a_q[i + CHUNK_DIGITS];
            assign b_ld = b_q[i + CHUNK_DIGITS];
            assign r_hi = r_q[i + CHUNK_DIGITS];
        end
        else
        begin : g_top
            assign a_ld = a_chunk[i + CHUNK_DIGITS - NCELL];
            assign b_ld = b_chunk[i + CHUNK_DIGITS - NCELL];
            assign r_hi = '0;
        end

        if (i + 1 < NCELL)
        begin : g_bup
            assign b_hi = b_q[i + 1];
        end
        else
        begin : g_btop
            assign b_hi = '0;
        end

        if (i > 0)
        begin : g_lo
            assign a_lo = a_q[i - 1];
            assign c_in = c_q[i - 1];
        end
        else
        begin : g_bottom
            assign a_lo = '0;
            assign c_in = carry0;
        end

        dbn_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .a_load   (a_ld),
            .b_load   (b_ld),
            .a_lower  (a_lo),
            .b_upper  (b_hi),
            .r_upper  (r_hi),
            .carry_in (c_in),
            .a        (a_q[i]),
            .b        (b_q[i]),
            .r        (r_q[i]),
            .carry    (c_q[i])
        );
    end

    // result beat from the bottom chunk of the cell row
    always_comb
    begin
        out_word = '0;
        for (int k = 0; k < CHUNK_DIGITS; k++)
        begin
            if (base + IW'(k) < IW'(DIGITS))
            begin
                out_word[DIGIT_W*k +: DIGIT_W] = r_q[k];
            end
        end
    end

    assign operands.ready        = (state_reg == S_LOAD);
    assign results.valid         = (state_reg == S_EMIT);
    assign results.result_digits = out_word;
    assign results.result_last   = (count_reg == CW'(NCHUNKS - 1));
    assign results.bad_digit     = bad_reg;

endmodule

[rtl/core/dbn_cell.sv]
// ----------------------------------------------------------------------------
// dbn_cell
// One digit position: holds a, b and result digits plus a carry that moves to
// the next higher cell on each multiply, add, subtract or flush step (carry-save accumulation).
// ----------------------------------------------------------------------------
module dbn_cell
    import dbn_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  digit_t     a_load,
    input  digit_t     b_load,
    input  digit_t     a_lower,
    input  digit_t     b_upper,
    input  digit_t     r_upper,
    input  digit_t     carry_in,
    output digit_t     a,
    output digit_t     b,
    output digit_t     r,
    output digit_t     carry
);

    digit_t       a_reg, a_next;
    digit_t       b_reg, b_next;
    digit_t       r_reg, r_next;
    digit_t       c_reg, c_next;
    logic [7:0]   prod;
    logic [6:0]   addend;
    logic [6:0]   total;
    logic [14:0]  scaled;
    digit_t       quo;
    digit_t       rem;

    // digit sum and its split into digit and carry
    always_comb
    begin
        prod   = 8'(a_reg) * 8'(ctrl.b_sel);
        addend = '0;
        total  = '0;
        case (ctrl.cmd)
            CMD_MUL:
            begin
                addend = 7'(prod);
                total  = 7'(r_reg) + addend + 7'(carry_in);
            end
            CMD_ADD:
            begin
                addend = 7'(a_reg) + 7'(b_reg);
                total  = addend + 7'(carry_in);
            end
            CMD_SUB:
            begin
                addend = 7'(a_reg) + 7'(4'd9 - b_reg);
                total  = addend + 7'(carry_in);
            end
            default:
            begin
                total = 7'(r_reg) + 7'(carry_in);
            end
        endcase
        scaled = 15'(total) * 15'(RECIP_TEN);
        quo    = scaled[RECIP_SHIFT +: DIGIT_W];
        rem    = 4'(total - 7'(quo) * 7'd10);
    end

    // command decoder
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        r_next = r_reg;
        c_next = c_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_LOAD:
            begin
                a_next = a_load;
                b_next = b_load;
            end
            CMD_CLEAR:
            begin
                r_next = '0;
                c_next = '0;
            end
            CMD_MUL:
            begin
                r_next = rem;
                c_next = quo;
                a_next = a_lower;
                b_next = b_upper;
            end
            CMD_ADD, CMD_SUB, CMD_FLUSH:
            begin
                r_next = rem;
                c_next = quo;
            end
            CMD_EMIT:
            begin
                r_next = r_upper;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
        c_reg <= c_next;
    end

    assign a     = a_reg;
    assign b     = b_reg;
    assign r     = r_reg;
    assign carry = c_reg;

endmodule
